/* hw/rtl/rwsf_pkg.sv */
`timescale 1ns / 1ps
package rwsf_pkg;

  localparam int unsigned MAX_CLIENTS = 255;
  localparam logic [7:0] CLIENT_CEIL = (MAX_CLIENTS > 255) ? 8'd255 : 8'(MAX_CLIENTS);
  localparam logic [3:0] ERR_CEIL    = 4'd15;

  localparam logic [2:0] FUNC_TICK       = 3'd0;
  localparam logic [2:0] FUNC_POWER      = 3'd1;
  localparam logic [2:0] FUNC_CONNECT    = 3'd2;
  localparam logic [2:0] FUNC_DISCONNECT = 3'd3;
  localparam logic [2:0] FUNC_WAKE_REQ   = 3'd4;
  localparam logic [2:0] FUNC_WAKE_DONE  = 3'd5;
  localparam logic [2:0] FUNC_ERROR      = 3'd6;
  localparam logic [2:0] FUNC_RESET      = 3'd7;

  localparam logic [2:0] MODE_INIT      = 3'd0;
  localparam logic [2:0] MODE_MONITOR   = 3'd1;
  localparam logic [2:0] MODE_TARGET_ON = 3'd2;
  localparam logic [2:0] MODE_CLIENT    = 3'd3;
  localparam logic [2:0] MODE_WAKING    = 3'd4;
  localparam logic [2:0] MODE_ERROR     = 3'd5;

  localparam logic REG_MONITOR_LIMIT = 1'b0;
  localparam logic REG_WAKING_LIMIT  = 1'b1;

  localparam logic [3:0] MONITOR_LIMIT_RST = 4'd5;
  localparam logic [3:0] WAKING_LIMIT_RST  = 4'd3;

  typedef struct packed {
    logic       wake_success;
    logic       power_on;
    logic [2:0] func;
  } rwsf_event_t;

  typedef struct packed {
    logic [3:0] monitor_error_limit;
    logic [3:0] waking_error_limit;
  } rwsf_cfg_t;

  typedef struct packed {
    logic [7:0] clients_now;
    logic [2:0] previous_state;
    logic       state_changed;
    logic [2:0] led_code;
    logic [2:0] state_code;
  } rwsf_result_t;

endpackage

/* hw/rtl/remote_wake_session_fsm_top.sv */
`timescale 1ns / 1ps
// A transaction accepted at an edge is captured in the input register and is then
// moved into the result register once the core takes it; a stall holds it in place.
// Throughput: one transaction per cycle while out_tready is not held low, set by the
// single-pass state update between the input register and the result register.
// Reset: synchronous rst_n clears the session state, sets the error limits
// to 5 and 3 and empties both pipeline registers.
module remote_wake_session_fsm_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // func[2:0], power_on[3], wake_success[4], zero[7:5]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // state_code[2:0], led_code[5:3], state_changed[6],
                                  // previous_state[9:7], clients_now[17:10], zero[23:18]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import rwsf_pkg::*;

  rwsf_cfg_t    cfg;
  rwsf_event_t  ev;
  logic         ev_valid;
  logic         ev_take;
  rwsf_result_t res;

  rwsf_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  rwsf_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .ev_valid  (ev_valid),
    .ev        (ev),
    .ev_take   (ev_take)
  );

  rwsf_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .ev_valid  (ev_valid),
    .ev        (ev),
    .ev_take   (ev_take),
    .out_valid (out_tvalid),
    .out_res   (res),
    .out_ready (out_tready)
  );

  assign out_tdata = {6'd0, res};

endmodule

/* hw/rtl/rwsf_cfg.sv */
`timescale 1ns / 1ps
module rwsf_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready,
  output rwsf_pkg::rwsf_cfg_t cfg
);
  import rwsf_pkg::*;

  logic [3:0] mon_lim_r;
  logic [3:0] wak_lim_r;
  logic       wr_en;
  logic       idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign idx        = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mon_lim_r <= MONITOR_LIMIT_RST;
      wak_lim_r <= WAKING_LIMIT_RST;
    end else if (wr_en) begin
      if (idx == REG_MONITOR_LIMIT) begin
        mon_lim_r <= cfg_pwdata[3:0];
      end else begin
        wak_lim_r <= cfg_pwdata[3:0];
      end
    end
  end

  always_comb begin
    cfg_prdata = 32'd0;
    if (idx == REG_MONITOR_LIMIT) begin
      cfg_prdata[3:0] = mon_lim_r;
    end else begin
      cfg_prdata[3:0] = wak_lim_r;
    end
  end

  assign cfg.monitor_error_limit = mon_lim_r;
  assign cfg.waking_error_limit  = wak_lim_r;

endmodule

/* hw/rtl/rwsf_in_stage.sv */
`timescale 1ns / 1ps
module rwsf_in_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,
  output logic                  ev_valid,
  output rwsf_pkg::rwsf_event_t ev,
  input  logic                  ev_take
);
  import rwsf_pkg::*;

  logic        ev_valid_r;
  logic        ev_valid_nxt;
  rwsf_event_t ev_r;
  logic        in_fire;

  assign in_tready = !ev_valid_r || ev_take;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    ev_valid_nxt = ev_valid_r;
    if (in_fire) begin
      ev_valid_nxt = 1'b1;
    end else if (ev_take) begin
      ev_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r <= 1'b0;
    end else begin
      ev_valid_r <= ev_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ev_r <= in_tdata[4:0];
    end
  end

  assign ev_valid = ev_valid_r;
  assign ev       = ev_r;

endmodule

/* hw/rtl/rwsf_core.sv */
`timescale 1ns / 1ps
module rwsf_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rwsf_pkg::rwsf_cfg_t    cfg,
  input  logic                   ev_valid,
  input  rwsf_pkg::rwsf_event_t  ev,
  output logic                   ev_take,
  output logic                   out_valid,
  output rwsf_pkg::rwsf_result_t out_res,
  input  logic                   out_ready
);
  import rwsf_pkg::*;

  logic [2:0]   cur_r, cur_nxt;
  logic [2:0]   prev_r, prev_nxt;
  logic [7:0]   cli_r, cli_nxt;
  logic [3:0]   err_r, err_nxt;
  logic         pwr_r, pwr_nxt;
  logic         pend_r, pend_nxt;
  logic         done_r, done_nxt;
  logic [2:0]   tgt;
  logic         changed;
  logic         proc;
  logic         out_valid_r;
  rwsf_result_t res_r;
  rwsf_result_t res_nxt;

  assign ev_take = !out_valid_r || out_ready;
  assign proc    = ev_valid && ev_take;

  always_comb begin
    tgt = cur_r;
    unique case (cur_r)
      MODE_INIT: tgt = MODE_MONITOR;
      MODE_MONITOR: begin
        if (pwr_r) begin
          tgt = MODE_TARGET_ON;
        end else if (cli_r != 8'd0) begin
          tgt = MODE_CLIENT;
        end else if (err_r > cfg.monitor_error_limit) begin
          tgt = MODE_ERROR;
        end
      end
      MODE_TARGET_ON: begin
        if (!pwr_r) begin
          tgt = MODE_MONITOR;
        end else if (cli_r != 8'd0) begin
          tgt = MODE_CLIENT;
        end
      end
      MODE_CLIENT: begin
        if (pend_r && !pwr_r) begin
          tgt = MODE_WAKING;
        end else if (cli_r == 8'd0) begin
          tgt = pwr_r ? MODE_TARGET_ON : MODE_MONITOR;
        end
      end
      MODE_WAKING: begin
        if (done_r) begin
          tgt = MODE_CLIENT;
        end else if (err_r > cfg.waking_error_limit) begin
          tgt = MODE_ERROR;
        end
      end
      MODE_ERROR: begin
        if (err_r == 4'd0) begin
          tgt = MODE_INIT;
        end
      end
      default: tgt = MODE_ERROR;
    endcase
  end

  always_comb begin
    cur_nxt  = cur_r;
    prev_nxt = prev_r;
    cli_nxt  = cli_r;
    err_nxt  = err_r;
    pwr_nxt  = pwr_r;
    pend_nxt = pend_r;
    done_nxt = done_r;
    changed  = 1'b0;
    unique case (ev.func)
      FUNC_TICK: begin
        if (tgt != cur_r) begin
          prev_nxt = cur_r;
          cur_nxt  = tgt;
          changed  = 1'b1;
        end
        if (cur_r == MODE_WAKING && done_r) begin
          pend_nxt = 1'b0;
          done_nxt = 1'b0;
        end
      end
      FUNC_POWER: pwr_nxt = ev.power_on;
      FUNC_CONNECT: begin
        if (cli_r < CLIENT_CEIL) begin
          cli_nxt = cli_r + 8'd1;
        end
      end
      FUNC_DISCONNECT: begin
        if (cli_r != 8'd0) begin
          cli_nxt = cli_r - 8'd1;
        end
      end
      FUNC_WAKE_REQ: pend_nxt = 1'b1;
      FUNC_WAKE_DONE: begin
        done_nxt = ev.wake_success;
        if (!ev.wake_success && err_r != ERR_CEIL) begin
          err_nxt = err_r + 4'd1;
        end
      end
      FUNC_ERROR: begin
        if (err_r != ERR_CEIL) begin
          err_nxt = err_r + 4'd1;
        end
      end
      FUNC_RESET: begin
        cur_nxt  = MODE_INIT;
        prev_nxt = MODE_INIT;
        cli_nxt  = 8'd0;
        err_nxt  = 4'd0;
        pwr_nxt  = 1'b0;
        pend_nxt = 1'b0;
        done_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    res_nxt.state_code     = cur_nxt;
    res_nxt.led_code       = (cur_nxt <= MODE_ERROR) ? cur_nxt : MODE_INIT;
    res_nxt.state_changed  = changed;
    res_nxt.previous_state = prev_nxt;
    res_nxt.clients_now    = cli_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= MODE_INIT;
      prev_r      <= MODE_INIT;
      cli_r       <= 8'd0;
      err_r       <= 4'd0;
      pwr_r       <= 1'b0;
      pend_r      <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (proc) begin
        cur_r  <= cur_nxt;
        prev_r <= prev_nxt;
        cli_r  <= cli_nxt;
        err_r  <= err_nxt;
        pwr_r  <= pwr_nxt;
        pend_r <= pend_nxt;
        done_r <= done_nxt;
      end
      if (ev_take) begin
        out_valid_r <= ev_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  a_changed_differs: assert property (@(posedge clk) disable iff (!rst_n)
    proc |=> (!res_r.state_changed || res_r.state_code != res_r.previous_state))
    else $error("transition reported without a state change");

  a_err_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && ev.func != FUNC_RESET) |=> (err_r >= $past(err_r)))
    else $error("error count dropped without soft reset");

  a_cli_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
    cli_r <= CLIENT_CEIL)
    else $error("client count above ceiling");

  a_wake_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && ev.func == FUNC_TICK && cur_r == MODE_WAKING && done_r)
      |=> (!pend_r && !done_r && cur_r == MODE_CLIENT))
    else $error("wake completion not consumed");

endmodule
